FILE: hw/rtl/sorted_table_lower_bound_search_defines.svh
// ----------------------------------------------------------------------------
// Sorted-table lower-bound search: assertion macros
// Shared helpers that clock every check on aclk and hold it off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_LOWER_BOUND_SEARCH_DEFINES_SVH
`define SORTED_TABLE_LOWER_BOUND_SEARCH_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define STLB_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("%m: assertion failed");

// The condition must never be true outside reset.
`define STLB_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

FILE: hw/rtl/stlb_pkg.sv
// ----------------------------------------------------------------------------
// Sorted-table lower-bound search: shared package
// Field widths, default parameters, request codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package stlb_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_ENTRY_BITS  = 32;

    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 11;

    // The entry index reaches 1024 entries at most.
    localparam int MAX_COUNT = 1024;

    localparam logic [POS_W-1:0] NO_POSITION = '1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic write_entry;  // store the input value at the input index
        logic load_search;  // capture key and set the search bounds
        logic addr_lo;      // read address is the low bound instead of the midpoint
        logic step;         // narrow the bounds with the entry just read
        logic check;        // compare the entry at the low bound with the key
        logic load_out;     // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic lo_lt_hi;     // bisection still has candidates
        logic lo_lt_n;      // low bound lies inside the entries in use
    } status_t;

endpackage

FILE: hw/rtl/sorted_table_lower_bound_search.sv
// ----------------------------------------------------------------------------
// Sorted-table lower-bound search
// Holds a table of signed entries, which the user must keep in ascending order,
// and answers lower-bound searches over the first entry_count entries by bisection.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                 Transaction
//  -------  ---------  --------------------------------------  ---------------
//  cfg      in         cfg_entry_count                         sets the count
//  s        in         s_req_type, s_entry_index, s_data_value  write or search
//  m        out        m_first_position, m_key_found           one per search
//
// A write transaction produces no result.
// Each bisection probe is one registered memory read plus one compare, and the
// single read port serializes the probes; a final read at the low bound checks
// for an equal entry when that bound lies inside the entries in use.
// One request is worked on at a time; the finished result waits in the output
// register, and the next request is taken while it waits.
// Reset (aresetn, synchronous, active low) clears the count and the control
// state; the table itself is undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module sorted_table_lower_bound_search #(
    parameter int TABLE_DEPTH = stlb_pkg::DEF_TABLE_DEPTH,
    parameter int ENTRY_BITS  = stlb_pkg::DEF_ENTRY_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write channel: the entry count register.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stlb_pkg::COUNT_W-1:0]        cfg_entry_count,

    // Request channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [stlb_pkg::INDEX_W-1:0]        s_entry_index,
    input  logic signed [stlb_pkg::VALUE_W-1:0] s_data_value,

    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [stlb_pkg::POS_W-1:0]   m_first_position,
    output logic                                m_key_found
);

    stlb_pkg::cmd_t    cmd;
    stlb_pkg::status_t sts;

    // The count register is always writable; software must change it only while
    // the block is idle, and the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    // The controller steps through the probes and owns both handshakes.
    stlb_control u_control (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath holds the table, the bounds and the output register.
    stlb_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_entry_count  (cfg_entry_count),
        .s_entry_index    (s_entry_index),
        .s_data_value     (s_data_value),
        .cmd              (cmd),
        .sts              (sts),
        .m_first_position (m_first_position),
        .m_key_found      (m_key_found)
    );

endmodule

FILE: hw/rtl/stlb_datapath.sv
// ----------------------------------------------------------------------------
// Sorted-table lower-bound search: datapath
// Entry memory, count register, search bounds, key and result registers.
// ----------------------------------------------------------------------------
module stlb_datapath #(
    parameter int TABLE_DEPTH = stlb_pkg::DEF_TABLE_DEPTH,
    parameter int ENTRY_BITS  = stlb_pkg::DEF_ENTRY_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write,
    input  logic [stlb_pkg::COUNT_W-1:0]        cfg_entry_count,
    input  logic [stlb_pkg::INDEX_W-1:0]        s_entry_index,
    input  logic signed [stlb_pkg::VALUE_W-1:0] s_data_value,
    input  stlb_pkg::cmd_t                      cmd,
    output stlb_pkg::status_t                   sts,
    output logic signed [stlb_pkg::POS_W-1:0]   m_first_position,
    output logic                                m_key_found
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CAP_INT = (TABLE_DEPTH < stlb_pkg::MAX_COUNT) ? TABLE_DEPTH
                                                                 : stlb_pkg::MAX_COUNT;
    localparam logic [stlb_pkg::COUNT_W-1:0] CAP = stlb_pkg::COUNT_W'(CAP_INT);

    logic signed [ENTRY_BITS-1:0] mem [TABLE_DEPTH];

    logic [stlb_pkg::COUNT_W-1:0] entry_count_reg;
    logic [stlb_pkg::COUNT_W-1:0] n_reg, lo_reg, hi_reg;
    logic [stlb_pkg::COUNT_W-1:0] lo_next, hi_next, mid, rd_sel;
    logic signed [ENTRY_BITS-1:0] key_reg, rdata_reg, entry_val;
    logic signed [63:0]           data_wide;
    logic                         found_reg;
    logic signed [stlb_pkg::POS_W-1:0] pos_reg;
    logic                         key_found_reg;

    logic [ADDR_W+stlb_pkg::COUNT_W-1:0] rd_wide;
    logic [ADDR_W+stlb_pkg::INDEX_W-1:0] wr_wide;
    logic [ADDR_W-1:0]                   raddr, waddr;
    logic                                wr_en;

    // Sign-extend from 32 bits, then wrap to the entry width.
    assign data_wide = 64'(s_data_value);
    assign entry_val = data_wide[ENTRY_BITS-1:0];

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_sel = cmd.addr_lo ? lo_reg : mid;

    assign rd_wide = {{ADDR_W{1'b0}}, rd_sel};
    assign raddr   = rd_wide[ADDR_W-1:0];
    assign wr_wide = {{ADDR_W{1'b0}}, s_entry_index};
    assign waddr   = wr_wide[ADDR_W-1:0];
    assign wr_en   = cmd.write_entry && (32'(s_entry_index) < 32'(TABLE_DEPTH));

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.load_search) begin
            lo_next = '0;
            hi_next = (entry_count_reg < CAP) ? entry_count_reg : CAP;
        end else if (cmd.step) begin
            if (rdata_reg >= key_reg) begin
                hi_next = mid;
            end else begin
                lo_next = mid + stlb_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= entry_val;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_write) begin
            entry_count_reg <= cfg_entry_count;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.load_search) begin
            n_reg   <= hi_next;
            key_reg <= entry_val;
        end
        if (cmd.check) begin
            found_reg <= (rdata_reg == key_reg);
        end
        if (cmd.load_out) begin
            pos_reg       <= sts.lo_lt_n ? signed'(lo_reg) : signed'(stlb_pkg::NO_POSITION);
            key_found_reg <= sts.lo_lt_n && found_reg;
        end
    end

    assign sts.lo_lt_hi = (lo_reg < hi_reg);
    assign sts.lo_lt_n  = (lo_reg < n_reg);

    assign m_first_position = pos_reg;
    assign m_key_found      = key_found_reg;

endmodule

FILE: hw/rtl/stlb_control.sv
// ----------------------------------------------------------------------------
// Sorted-table lower-bound search: controller
// Sequences writes, bisection probes, the final equality check and the
// output handshake.
// ----------------------------------------------------------------------------
`include "sorted_table_lower_bound_search_defines.svh"

module stlb_control (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    output logic              m_valid,
    input  logic              m_ready,
    input  stlb_pkg::status_t sts,
    output stlb_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_FCMP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == stlb_pkg::REQ_SEARCH) begin
                        cmd.load_search = 1'b1;
                        state_next      = S_PROBE;
                    end else begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            S_PROBE: begin
                cmd.addr_lo = !sts.lo_lt_hi;
                if (sts.lo_lt_hi) begin
                    state_next = S_CMP;
                end else if (sts.lo_lt_n) begin
                    state_next = S_FCMP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CMP: begin
                cmd.step   = 1'b1;
                state_next = S_PROBE;
            end
            S_FCMP: begin
                cmd.check  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `STLB_ASSERT(a_cmp_after_probe, (state_reg == S_CMP) |-> ($past(state_reg) == S_PROBE))
    `STLB_ASSERT(a_fcmp_after_probe, (state_reg == S_FCMP) |-> ($past(state_reg) == S_PROBE))
    `STLB_ASSERT(a_load_when_free, cmd.load_out |-> out_free)
    `STLB_ASSERT_NEVER(a_search_while_busy, cmd.load_search && (state_reg != S_IDLE))

endmodule

FILE: verif/lower_bound_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lower-bound search checker
// Watches the configuration, request and result channels, keeps its own copy
// of the table and the entry count, predicts each search answer and compares
// every accepted result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module lower_bound_checker (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [stlb_pkg::COUNT_W-1:0]        cfg_entry_count,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [stlb_pkg::INDEX_W-1:0]        s_entry_index,
    input  logic signed [stlb_pkg::VALUE_W-1:0] s_data_value,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [stlb_pkg::POS_W-1:0]   m_first_position,
    input  logic                                m_key_found,

    output int                                  mismatch_count,
    output int                                  answers_outstanding
);
    import stlb_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    found;
    } bound_answer_t;

    logic signed [VALUE_W-1:0] entry_copy [DEF_TABLE_DEPTH];
    logic [COUNT_W-1:0]        count_copy;
    bound_answer_t             answer_q [$];
    int                        errs;

    initial begin
        errs                = 0;
        count_copy          = '0;
        mismatch_count      = 0;
        answers_outstanding = 0;
    end

    // Bisect the entries in use for the first one that is not below the key.
    function automatic bound_answer_t lower_bound(input logic signed [VALUE_W-1:0] key);
        bound_answer_t answer;
        int unsigned   n;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        n  = (count_copy > MAX_COUNT) ? MAX_COUNT : count_copy;
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (entry_copy[mid] >= key) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        if (lo < n) begin
            answer.position = POS_W'(lo);
            answer.found    = (entry_copy[lo] == key);
        end else begin
            answer.position = NO_POSITION;
            answer.found    = 1'b0;
        end
        return answer;
    endfunction

    task automatic report_mismatch(input string what);
        errs++;
        $display("[%0t] lower_bound_checker: %s", $time, what);
    endtask

    always @(posedge aclk) begin : watch
        bound_answer_t want;
        if (!aresetn) begin
            count_copy = '0;
            answer_q.delete();
        end else begin
            // Results are retired before new searches are queued, since a
            // search accepted at this edge cannot answer at the same edge.
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: position %0d, found %0b",
                                              m_first_position, m_key_found));
                end else begin
                    want = answer_q.pop_front();
                    if (m_first_position !== want.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  m_first_position, want.position));
                    end
                    if (m_key_found !== want.found) begin
                        report_mismatch($sformatf("found flag %0b, expected %0b at position %0d",
                                                  m_key_found, want.found, want.position));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                count_copy = cfg_entry_count;
            end
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_SEARCH) begin
                    answer_q.push_back(lower_bound(s_data_value));
                end else begin
                    entry_copy[s_entry_index] = s_data_value;
                end
            end
        end
        mismatch_count      <= errs;
        answers_outstanding <= answer_q.size();
    end

endmodule

FILE: verif/sorted_table_lower_bound_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted-table lower-bound search testbench
// Fills the table with ascending entries, sets a range of entry counts and
// issues searches whose keys hit, miss and straddle the stored values. A
// separate checker predicts every answer; this module drives the traffic,
// stalls the result channel and gives the verdict.
// ----------------------------------------------------------------------------
module sorted_table_lower_bound_search_tb;
    import stlb_pkg::*;

    // Items issued in each randomized phase, after the directed opening.
    localparam int PHASE_ITEMS   = 50;
    localparam int NUM_PHASES    = 14;
    // Writes give no result, so this many quiet cycles after the last answer
    // guarantee the block is idle before a count write.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic                        aclk;
    logic                        aresetn         = 1'b0;
    logic                        cfg_valid       = 1'b0;
    logic                        cfg_ready;
    logic [COUNT_W-1:0]          cfg_entry_count = '0;
    logic                        s_valid         = 1'b0;
    logic                        s_ready;
    logic                        s_req_type      = REQ_WRITE;
    logic [INDEX_W-1:0]          s_entry_index   = '0;
    logic signed [VALUE_W-1:0]   s_data_value    = '0;
    logic                        m_valid;
    logic                        m_ready         = 1'b0;
    logic signed [POS_W-1:0]     m_first_position;
    logic                        m_key_found;

    int                          mismatch_count;
    int                          answers_outstanding;

    // Stimulus-side view of the table. It only steers key and value choices;
    // the checker keeps its own copy for prediction.
    logic signed [VALUE_W-1:0]   shadow    [DEF_TABLE_DEPTH];
    bit                          shadow_ok [DEF_TABLE_DEPTH];
    int                          active_n   = 0;
    int                          burst_left = 0;
    int                          ready_hold = 0;
    int unsigned                 cycle_cnt  = 0;

    // Counts for the randomized phases. Full depth comes first so that every
    // entry is written before any larger or random count is used; a negative
    // value asks for a random count over the whole register range.
    int count_plan [NUM_PHASES] = '{1024, 2047, 1, 2, 3, 7, 16, 33, 64, 1023, 0,
                                    -1, 777, -1};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    sorted_table_lower_bound_search u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_entry_count  (cfg_entry_count),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_entry_index    (s_entry_index),
        .s_data_value     (s_data_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_first_position (m_first_position),
        .m_key_found      (m_key_found)
    );

    lower_bound_checker u_lb_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_entry_count     (cfg_entry_count),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_entry_index       (s_entry_index),
        .s_data_value        (s_data_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_first_position    (m_first_position),
        .m_key_found         (m_key_found),
        .mismatch_count      (mismatch_count),
        .answers_outstanding (answers_outstanding)
    );

    // The result side mixes three behaviors: long open stretches, long
    // stalls and a cycle-by-cycle coin flip. Each lasts a random time, so
    // backpressure lands on every phase of a search.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready    <= 1'b1;
                    ready_hold <= $urandom_range(20, 80);
                end
                1: begin
                    m_ready    <= 1'b0;
                    ready_hold <= $urandom_range(1, 30);
                end
                default: begin
                    m_ready    <= 1'($urandom_range(0, 1));
                    ready_hold <= 0;
                end
            endcase
        end
    end

    // A hung handshake ends the run here rather than never.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. The sender
    // works in bursts: when a burst runs out, valid drops for a random gap and
    // a new burst length is drawn, sometimes long enough to run back to back.
    task automatic push_req(input logic req, input logic [INDEX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] val);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_entry_index <= idx;
        s_data_value  <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic put_entry(input logic [INDEX_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] val);
        push_req(REQ_WRITE, idx, val);
        shadow[idx]    = val;
        shadow_ok[idx] = 1'b1;
    endtask

    // The index field is unused by a search, so it carries noise.
    task automatic seek(input logic signed [VALUE_W-1:0] key);
        push_req(REQ_SEARCH, INDEX_W'($urandom_range(0, DEF_TABLE_DEPTH - 1)), key);
    endtask

    // Stop sending and wait until every search has answered. The count seen
    // from the checker is registered, hence the extra wait before polling.
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (answers_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called while the block is idle.
    task automatic write_count(input int n);
        cfg_valid       <= 1'b1;
        cfg_entry_count <= COUNT_W'(n);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        active_n = (n > MAX_COUNT) ? MAX_COUNT : n;
    endtask

    // Write an ascending run into entries 0..n-1. Steps of zero create runs
    // of duplicates, and large steps clamp at the top of the signed range.
    task automatic load_sorted(input int n);
        longint v;
        int     raw;
        case ($urandom_range(0, 3))
            0: v = KEY_MIN;
            1: begin
                raw = $urandom;
                v   = raw;
            end
            2: v = longint'($urandom_range(0, 100)) - 50;
            default: v = -longint'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
        for (int i = 0; i < n; i++) begin
            put_entry(INDEX_W'(i), VALUE_W'(v));
            case ($urandom_range(0, 7))
                0, 1: ;
                2, 3, 4: v += $urandom_range(1, 4);
                5: v += $urandom_range(1, 1000);
                6: v += $urandom_range(1, 1 << 24);
                default: v += $urandom_range(1, 1 << 30);
            endcase
            if (v > KEY_MAX) begin
                v = KEY_MAX;
            end
        end
    endtask

    // Every entry a search may read must have been written. Small tables are
    // refreshed each phase; large ones only when a hole remains.
    task automatic prepare_table(input int n);
        bit hole;
        hole = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!shadow_ok[i]) begin
                hole = 1'b1;
            end
        end
        if (n <= 64 || hole) begin
            load_sorted(n);
        end
    endtask

    // Keys mostly land on a stored value or just beside one, which is where
    // the found flag and the boundary of the lower bound get exercised.
    function automatic logic signed [VALUE_W-1:0] pick_key(input int n);
        logic signed [VALUE_W-1:0] probe;
        probe = (n > 0) ? shadow[$urandom_range(0, n - 1)] : KEY_MIN;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return probe;
            4: return probe + 1;
            5: return probe - 1;
            6: return KEY_MIN;
            7: return KEY_MAX;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Mostly searches; some writes that keep the table in order by picking a
    // value between the neighbors; a few raw writes anywhere, which may leave
    // the table out of order.
    task automatic random_item();
        int     pick;
        int     idx;
        longint lo_bound;
        longint hi_bound;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            seek(pick_key(active_n));
        end else if (pick < 95 && active_n > 0) begin
            idx      = $urandom_range(0, active_n - 1);
            lo_bound = (idx > 0) ? shadow[idx - 1] : KEY_MIN;
            hi_bound = (idx < active_n - 1) ? shadow[idx + 1] : KEY_MAX;
            if (hi_bound < lo_bound) begin
                hi_bound = lo_bound;
            end
            put_entry(INDEX_W'(idx),
                      VALUE_W'(lo_bound + ({$urandom, $urandom} % (hi_bound - lo_bound + 1))));
        end else begin
            put_entry(INDEX_W'($urandom_range(0, DEF_TABLE_DEPTH - 1)), VALUE_W'($urandom));
        end
    endtask

    initial begin
        int n;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table straight out of reset: every search misses.
        seek(32'sd0);
        seek(KEY_MIN);
        seek(KEY_MAX);

        // One entry at the bottom of the range.
        drain_results();
        write_count(1);
        put_entry(10'd0, KEY_MIN);
        seek(KEY_MIN);
        seek(KEY_MAX);
        seek(32'sd0);

        // Five entries with a duplicate pair and the top value at the end.
        drain_results();
        write_count(5);
        put_entry(10'd0, -32'sd5);
        put_entry(10'd1, 32'sd0);
        put_entry(10'd2, 32'sd0);
        put_entry(10'd3, 32'sd7);
        put_entry(10'd4, KEY_MAX);
        seek(32'sd0);
        seek(32'sd1);
        seek(-32'sd6);
        seek(KEY_MAX);
        seek(32'sd8);
        seek(KEY_MIN);
        // Break the ordering, then write past the entries in use.
        put_entry(10'd2, -32'sd100);
        seek(-32'sd100);
        put_entry(10'd1023, VALUE_W'($urandom));

        // Randomized phases, each with its own count. Halfway through every
        // phase the sender holds off until all answers are back.
        for (int p = 0; p < NUM_PHASES; p++) begin
            n = (count_plan[p] < 0) ? $urandom_range(0, 2047) : count_plan[p];
            drain_results();
            write_count(n);
            prepare_table(active_n);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                random_item();
            end
        end

        drain_results();
        if (mismatch_count == 0 && answers_outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
